// File: hw/rtl/tvp_pkg.sv
// tvp_pkg: types and constants shared by the trapezoidal velocity profile core
// no dependencies
package tvp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned VelW  = 24;
  localparam int unsigned DistW = 32;

  localparam logic [TimeW-1:0] TimeSat = '1;
  localparam logic [VelW-1:0]  VelSat  = '1;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_DIST  = 2'd0,
    REG_VMAX  = 2'd1,
    REG_AMAX  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // derived profile times handed from the solver to the sampler
  typedef struct packed {
    logic [TimeW-1:0] accel_end;
    logic [TimeW-1:0] cruise_end;
    logic [TimeW-1:0] total;
    logic [VelW-1:0]  peak;
  } profile_t;

endpackage

// File: hw/rtl/tvp_solver.sv
// tvp_solver: derives phase ends from distance, velocity and acceleration
// multi-cycle shift/subtract divider and bit-serial square root; uses tvp_pkg
module tvp_solver #(
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31:0]             dist_in,
  input  logic [23:0]             vel,
  input  logic [23:0]             acc,
  output logic                    busy,
  output logic                    done,
  output tvp_pkg::profile_t       prof
);
  import tvp_pkg::*;

  localparam int unsigned QW = 64;
  localparam int unsigned PW = 56;  // d*a and v*v fit in 56 bits
  localparam int unsigned DW = 48;  // a*v
  localparam int unsigned TF = TIME_FRAC_BITS;
  localparam int unsigned CW = 7;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CMP, S_DIV, S_SQRT, S_ACC2, S_CRU, S_SUM, S_SUM2
  } st_t;

  st_t st_r;
  logic [PW-1:0] da_r, vv_r;
  logic [DW-1:0] av_r;
  logic [23:0]   v_r, a_r;
  logic          tri_r;
  // divider
  logic [QW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] dv_r;
  logic [PW-1:0] num_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] nbits_r;
  logic          ovf_r;
  // sqrt
  logic [QW-1:0] sn_r, sres_r, sbit_r;
  logic [TimeW-1:0] tacc_r, tcru_r;
  logic [55:0]      pk_r;
  profile_t prof_r;
  logic done_r;
  // total registered in the cycle after the cruise end settles
  logic [TimeW-1:0] total_r;

  logic [DW:0]    rem_sh;
  logic           num_bit;
  logic [QW:0]    s_try;
  logic [TimeW:0] sum1, sum2;

  always_comb begin
    // next numerator bit: integer bits of num first, then zeros
    num_bit = (cnt_r < CW'(PW)) ? num_r[PW-1] : 1'b0;
    rem_sh  = {rem_r[DW-1:0], num_bit};
    s_try   = {1'b0, sres_r} + {1'b0, sbit_r};
    sum1    = {1'b0, tacc_r} + {1'b0, tcru_r};
    sum2    = {1'b0, prof_r.cruise_end} + {1'b0, tacc_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      prof_r <= '0;
    end else begin
      done_r <= (st_r == S_SUM2);
      case (st_r)
        S_IDLE: begin
          if (start) begin
            v_r  <= (vel == '0) ? 24'd1 : vel;
            a_r  <= (acc == '0) ? 24'd1 : acc;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          da_r <= PW'(dist_in) * PW'(a_r);
          vv_r <= PW'(v_r) * PW'(v_r);
          av_r <= DW'(a_r) * DW'(v_r);
          st_r <= S_CMP;
        end
        S_CMP: begin
          tri_r <= da_r < vv_r;
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          cnt_r <= '0;
          if (da_r < vv_r) begin
            // floor(d * 2^2T / a)
            num_r   <= PW'(dist_in) << (PW - DistW);
            nbits_r <= CW'(DistW + 2 * TF);
            dv_r    <= DW'(a_r);
          end else begin
            // floor(v * 2^T / a)
            num_r   <= PW'(v_r) << (PW - VelW);
            nbits_r <= CW'(VelW + TF);
            dv_r    <= DW'(a_r);
          end
          st_r <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per cycle; numerator bits fed msb first
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (q_r[QW-1]) ovf_r <= 1'b1;
          if (rem_sh >= {1'b0, dv_r}) begin
            rem_r <= rem_sh - {1'b0, dv_r};
            q_r   <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[QW-2:0], 1'b0};
          end
          if (cnt_r == nbits_r - 1'b1) st_r <= S_ACC2;
        end
        S_ACC2: begin
          if (tri_r) begin
            sn_r   <= q_r;
            sres_r <= '0;
            sbit_r <= 64'd1 << 62;
            st_r   <= S_SQRT;
          end else begin
            tacc_r <= (q_r > QW'(TimeSat)) ? TimeSat : q_r[TimeW-1:0];
            // cruise time: (d*a - v*v) * 2^T / (a*v)
            num_r   <= da_r - vv_r;
            nbits_r <= CW'(PW + TF);
            dv_r    <= av_r;
            rem_r   <= '0;
            q_r     <= '0;
            ovf_r   <= 1'b0;
            cnt_r   <= '0;
            st_r    <= S_CRU;
          end
        end
        S_CRU: begin
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (q_r[QW-1]) ovf_r <= 1'b1;
          if (rem_sh >= {1'b0, dv_r}) begin
            rem_r <= rem_sh - {1'b0, dv_r};
            q_r   <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[QW-2:0], 1'b0};
          end
          if (cnt_r == nbits_r - 1'b1) begin
            st_r <= S_SUM;
          end
        end
        S_SQRT: begin
          // two radicand bits per cycle
          if (sbit_r == '0) begin
            tacc_r <= ovf_r ? TimeSat :
                      ((sres_r > QW'(TimeSat)) ? TimeSat : sres_r[TimeW-1:0]);
            q_r    <= '0;
            ovf_r  <= 1'b0;
            st_r   <= S_SUM;
          end else begin
            if (sn_r >= s_try[QW-1:0]) begin
              sn_r   <= sn_r - s_try[QW-1:0];
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_SUM: begin
          tcru_r <= (tri_r) ? '0 :
                    ((ovf_r || q_r > QW'(TimeSat)) ? TimeSat : q_r[TimeW-1:0]);
          pk_r   <= 56'(a_r) * 56'(tacc_r);
          st_r   <= S_SUM2;
        end
        S_SUM2: begin
          prof_r.accel_end  <= tacc_r;
          prof_r.cruise_end <= sum1[TimeW] ? TimeSat : sum1[TimeW-1:0];
          if (tri_r) begin
            prof_r.peak <= ((pk_r >> TF) > 56'(VelSat)) ? VelSat :
                           VelW'(pk_r >> TF);
          end else begin
            prof_r.peak <= v_r;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_r <= sum2[TimeW] ? TimeSat : sum2[TimeW-1:0];
  end

  always_comb begin
    prof       = prof_r;
    prof.total = total_r;
  end
  assign busy = (st_r != S_IDLE) || done_r;
  assign done = done_r;

endmodule

// File: hw/rtl/tvp_sampler.sv
// tvp_sampler: per-sample phase classify and speed compute, two stages
// uses tvp_pkg
module tvp_sampler #(
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  output logic              in_r,
  input  logic [31:0]       t_in,
  input  tvp_pkg::profile_t prof,
  input  logic [23:0]       acc,
  output logic              out_v,
  input  logic              out_r,
  output logic [58:0]       out_d
);
  import tvp_pkg::*;

  // stage 1 registers: phase and multiplicand
  logic        s1_v_r;
  phase_t      s1_ph_r;
  logic [31:0] s1_dt_r;
  // stage 2 (output) registers
  logic        s2_v_r;
  logic [58:0] s2_d_r;

  logic [31:0] dt_nxt;
  phase_t      ph_nxt;
  logic [55:0] prod;
  logic [55:0] sc;
  logic [23:0] vel;
  logic        adv2, adv1;

  always_comb begin
    if (t_in < prof.accel_end) begin
      ph_nxt = PH_ACCEL;  dt_nxt = t_in;
    end else if (t_in < prof.cruise_end) begin
      ph_nxt = PH_CRUISE; dt_nxt = '0;
    end else if (t_in < prof.total) begin
      ph_nxt = PH_DECEL;  dt_nxt = t_in - prof.cruise_end;
    end else begin
      ph_nxt = PH_DONE;   dt_nxt = '0;
    end
  end

  assign prod = 56'(acc) * 56'(s1_dt_r);
  assign sc   = prod >> TIME_FRAC_BITS;

  always_comb begin
    case (s1_ph_r)
      PH_ACCEL:  vel = (sc > 56'(VelSat)) ? VelSat : sc[23:0];
      PH_CRUISE: vel = prof.peak;
      PH_DECEL:  vel = (sc >= 56'(prof.peak)) ? '0 : prof.peak - sc[23:0];
      default:   vel = '0;
    endcase
  end

  assign adv2 = !s2_v_r || out_r;
  assign adv1 = !s1_v_r || adv2;
  assign in_r = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_v;
      if (adv2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_v) begin
      s1_ph_r <= ph_nxt;
      s1_dt_r <= dt_nxt;
    end
    if (adv2 && s1_v_r) begin
      s2_d_r <= {prof.total, (s1_ph_r == PH_DONE), s1_ph_r, vel};
    end
  end

  assign out_v = s2_v_r;
  assign out_d = s2_d_r;

endmodule

// File: hw/rtl/tvp_front.sv
// tvp_front: accepts samples into a two-entry queue, holds them while
// the profile is stale or being derived; uses tvp_pkg
module tvp_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        prof_ok,
  output logic        q_v,
  input  logic        q_r,
  output logic [31:0] q_d
);
  import tvp_pkg::*;

  logic [31:0] mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_tready = cnt_r != 2'd2;
  assign push = in_tvalid && in_tready;
  assign q_v  = (cnt_r != 2'd0) && prof_ok;
  assign pop  = q_v && q_r;
  assign q_d  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_tdata;
  end

endmodule

// File: hw/rtl/trapezoidal_velocity_profile_core.sv
// trapezoidal_velocity_profile_core: top level
// depends on tvp_pkg, tvp_front, tvp_solver, tvp_sampler
//
// Usage: write travel_distance (index 0), max_velocity (1) and
// max_acceleration (2) through cfg_*, then stream sample times in on
// in_tdata (Q16.16 s). Each sample yields one result on out_tdata:
// velocity [23:0], phase [25:24], finished [26], move_time [58:27].
// After reset or any register write the profile is re-derived: a serial
// divider (one quotient bit a cycle: a 64-bit quotient for a triangular
// move, 40- and 72-bit quotients for the acceleration and cruise times)
// and a square root (one result bit a cycle) hold samples in the input
// queue until the derivation ends; a write during the derivation makes
// its result stale, and a new derivation follows once it ends.
// Otherwise one sample a cycle is taken while out_tready stays high;
// out_tvalid rises after queue, classify and multiply, output register.
// A stalled receiver fills the output register, the stage behind it and
// the two-entry queue before in_tready drops; nothing is lost.
// Reset clears queue pointers, pipeline valids and profile except total.
module trapezoidal_velocity_profile_core #(
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // velocity, phase, finished, move_time
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tvp_pkg::*;

  logic [31:0] dist_r;
  logic [23:0] vel_r, acc_r;
  logic        valid_r, run_r, redo_r;
  logic        s_busy, s_done;
  profile_t    prof;
  logic        q_v, q_rdy;
  logic [31:0] q_d;
  logic [58:0] res;
  logic [23:0] acc_eff;

  assign acc_eff = (acc_r == '0) ? 24'd1 : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0; vel_r <= 24'd12800; acc_r <= 24'd25600;
      valid_r <= 1'b0; run_r <= 1'b0; redo_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        // a write during a derivation makes its result stale
        case (reg_idx_t'(cfg_index))
          REG_DIST: begin dist_r <= cfg_data; valid_r <= 1'b0; redo_r <= run_r; end
          REG_VMAX: begin vel_r <= cfg_data[23:0]; valid_r <= 1'b0; redo_r <= run_r; end
          REG_AMAX: begin acc_r <= cfg_data[23:0]; valid_r <= 1'b0; redo_r <= run_r; end
          default: ;
        endcase
      end else if (s_done) begin
        valid_r <= !redo_r; run_r <= 1'b0; redo_r <= 1'b0;
      end else if (!valid_r && !run_r && !s_busy) begin
        run_r <= 1'b1;
      end
    end
  end

  tvp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .prof_ok(valid_r), .q_v, .q_r(q_rdy), .q_d
  );

  tvp_solver #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_solver (
    .clk, .rst_n, .start(run_r && !s_busy && !valid_r),
    .dist_in(dist_r), .vel(vel_r), .acc(acc_r),
    .busy(s_busy), .done(s_done), .prof
  );

  tvp_sampler #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_samp (
    .clk, .rst_n, .in_v(q_v), .in_r(q_rdy), .t_in(q_d), .prof,
    .acc(acc_eff), .out_v(out_tvalid), .out_r(out_tready), .out_d(res)
  );

  assign out_tdata = {5'd0, res};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");
  a_no_issue_stale: assert property (@(posedge clk) disable iff (!rst_n)
    q_v |-> valid_r)
    else $error("sample issued with stale profile");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s_done |-> run_r)
    else $error("solver finished without request");

endmodule
